[rtl/fifo_page_replacement_defines.svh]
// ----------------------------------------------------------------------------
// FIFO page replacement - assertion macros
// Shared assertion macros, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIFO_PAGE_REPLACEMENT_DEFINES_SVH
`define FIFO_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication.
`define FPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/fpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO page replacement package
// Widths, reset values and the control token that travels down the cell row.
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;

    localparam int CFG_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 16;
    // Frame index width covers frame indices for up to 64 frames.
    localparam int IDX_W   = 6;
    localparam int NUM_W   = IDX_W + 1;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
    localparam logic [COUNT_W-1:0] FAULT_MAX = '1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [NUM_W-1:0] t_num;

    typedef struct packed {
        logic valid;
        logic found;
        logic ev_valid;
        t_idx match;
        t_idx fill;
    } t_ctl;

endpackage

[rtl/fpr_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO page replacement - frame cell
// Holds one page frame, checks the passing lookup against it and registers the
// lookup to hand it on to the next cell.
// ----------------------------------------------------------------------------
module fpr_cell #(
    parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF,
    parameter int INDEX     = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpr_pkg::t_num        i_num,
    input  fpr_pkg::t_ctl        i_ctl,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [PAGE_BITS-1:0] i_ev_page,
    input  logic                 i_wr_en,
    input  logic [PAGE_BITS-1:0] i_wr_page,
    output fpr_pkg::t_ctl        o_ctl,
    output logic [PAGE_BITS-1:0] o_page,
    output logic [PAGE_BITS-1:0] o_ev_page
);
    import fpr_pkg::*;

    localparam t_idx MY_IDX = IDX_W'(INDEX);

    logic [PAGE_BITS-1:0] r_frame;
    logic                 r_frame_valid;
    t_ctl                 r_ctl;
    t_ctl                 n_ctl;
    logic [PAGE_BITS-1:0] r_page;
    logic [PAGE_BITS-1:0] r_ev_page;
    logic [PAGE_BITS-1:0] n_ev_page;
    logic                 active;
    logic                 is_fill;

    assign active  = {1'b0, MY_IDX} < i_num;
    assign is_fill = (i_ctl.fill == MY_IDX);

    always_comb begin
        n_ctl     = i_ctl;
        n_ev_page = i_ev_page;
        // The first matching frame wins, so lower cells take priority.
        if (active && r_frame_valid && !i_ctl.found && r_frame == i_page) begin
            n_ctl.found = 1'b1;
            n_ctl.match = MY_IDX;
        end
        if (is_fill) begin
            n_ctl.ev_valid = r_frame_valid;
            n_ev_page      = r_frame_valid ? r_frame : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid <= 1'b0;
            r_ctl         <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (i_wr_en) begin
                r_frame_valid <= 1'b1;
            end
        end
        if (i_wr_en) begin
            r_frame <= i_wr_page;
        end
        r_page    <= i_page;
        r_ev_page <= n_ev_page;
    end

    assign o_ctl     = r_ctl;
    assign o_page    = r_page;
    assign o_ev_page = r_ev_page;

endmodule

[rtl/fifo_page_replacement.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO page replacement
// Looks up page references in a row of frame cells and replaces frames in
// FIFO order on a fault, keeping a saturating fault count.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  request   in         start, busy               i_page_number
//  result    out        o_valid (one-cycle pulse)  o_hit, o_slot, o_evicted_valid,
//                                                  o_evicted_page, o_fault_count
//  config    in         i_cfg_we                   i_cfg_wdata (frames in use)
//
//  A reference walks the row of FRAMES cells, one cell per cycle, and the result
//  strobe is registered from the last cell's output; busy stays high until the
//  frame update is done, so a new reference is taken only after the last is through.
//  Synchronous reset empties all frames, zeroes the fill pointer and the fault
//  count and sets frames in use to 16. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module fifo_page_replacement #(
    parameter int FRAMES    = fpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [PAGE_BITS-1:0]        i_page_number,
    input  logic                        i_cfg_we,
    input  logic [fpr_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [fpr_pkg::SLOT_W-1:0]  o_slot,
    output logic                        o_evicted_valid,
    output logic [PAGE_BITS-1:0]        o_evicted_page,
    output logic [fpr_pkg::COUNT_W-1:0] o_fault_count
);
    import fpr_pkg::*;

    logic [CFG_W-1:0]     r_cfg;
    logic                 r_busy;
    t_idx                 r_fill_ptr;
    logic [COUNT_W-1:0]   r_fault_total;
    logic                 r_valid;
    logic                 r_hit;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page;

    t_num                 cfg_ext;
    t_num                 num;
    t_idx                 fill_slot;
    t_num                 next_ptr;
    logic                 accept;
    t_ctl                 head;
    t_ctl                 tail;

    t_ctl                 ctl_chain  [FRAMES+1];
    logic [PAGE_BITS-1:0] page_chain [FRAMES+1];
    logic [PAGE_BITS-1:0] ev_chain   [FRAMES+1];

    // Out-of-range counts clamp to the row: zero acts as one.
    assign cfg_ext = NUM_W'(r_cfg);
    always_comb begin
        if (cfg_ext == '0) begin
            num = NUM_W'(1);
        end else if (cfg_ext > NUM_W'(FRAMES)) begin
            num = NUM_W'(FRAMES);
        end else begin
            num = cfg_ext;
        end
    end

    // A pointer left beyond a shrunken count restarts at frame zero.
    assign fill_slot = ({1'b0, r_fill_ptr} < num) ? r_fill_ptr : '0;

    assign accept = start && !r_busy;

    always_comb begin
        head          = '0;
        head.valid    = accept;
        head.fill     = fill_slot;
    end

    assign ctl_chain[0]  = head;
    assign page_chain[0] = i_page_number;
    assign ev_chain[0]   = '0;
    assign tail          = ctl_chain[FRAMES];

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        fpr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .INDEX     (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_num     (num),
            .i_ctl     (ctl_chain[g]),
            .i_page    (page_chain[g]),
            .i_ev_page (ev_chain[g]),
            .i_wr_en   (tail.valid && !tail.found && tail.fill == IDX_W'(g)),
            .i_wr_page (page_chain[FRAMES]),
            .o_ctl     (ctl_chain[g+1]),
            .o_page    (page_chain[g+1]),
            .o_ev_page (ev_chain[g+1])
        );
    end

    assign next_ptr = {1'b0, tail.fill} + NUM_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_fill_ptr    <= '0;
            r_fault_total <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_valid <= tail.valid;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (tail.valid) begin
                r_busy <= 1'b0;
            end
            if (tail.valid && !tail.found) begin
                r_fill_ptr <= (next_ptr < num) ? next_ptr[IDX_W-1:0] : '0;
                if (r_fault_total != FAULT_MAX) begin
                    r_fault_total <= r_fault_total + COUNT_W'(1);
                end
            end
        end
        if (tail.valid) begin
            r_hit      <= tail.found;
            r_slot     <= tail.found ? tail.match[SLOT_W-1:0] : tail.fill[SLOT_W-1:0];
            r_ev_valid <= !tail.found && tail.ev_valid;
            r_ev_page  <= tail.found ? '0 : ev_chain[FRAMES];
        end
    end

    assign busy            = r_busy;
    assign o_valid         = r_valid;
    assign o_hit           = r_hit;
    assign o_slot          = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_count   = r_fault_total;

endmodule

[rtl/fpr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO page replacement - port checker
// Watches the top-level ports for transaction ordering and result sanity.
// ----------------------------------------------------------------------------
`include "fifo_page_replacement_defines.svh"

module fpr_checker #(
    parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic                        o_hit,
    input logic                        o_evicted_valid,
    input logic [PAGE_BITS-1:0]        o_evicted_page,
    input logic [fpr_pkg::COUNT_W-1:0] o_fault_count
);
    import fpr_pkg::*;

    // An accepted transaction keeps the block busy until its result.
    `FPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

    // Only one transaction is in flight, so results never come back to back.
    `FPR_ASSERT_NEXT(a_single_pulse, o_valid, !o_valid, "result strobe held two cycles")

    // A hit never evicts anything.
    `FPR_ASSERT_NOW(a_hit_no_evict, o_valid && o_hit,
        !o_evicted_valid && o_evicted_page == '0, "hit reported an eviction")

    // The fault count only moves when a result is issued.
    `FPR_ASSERT_NOW(a_count_stable, $past(i_rst_n) && !o_valid, $stable(o_fault_count),
        "fault count changed without a result")

endmodule

bind fifo_page_replacement fpr_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_fpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid),
    .o_evicted_page  (o_evicted_page),
    .o_fault_count   (o_fault_count)
);
